FILE: src/integer_to_ascii_formatter_defines.svh
// assertion macros used by the formatter back end
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH

// same-cycle implication
`define I2A_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("i2a: same-cycle check failed");

// next-cycle implication
`define I2A_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("i2a: next-cycle check failed");

`endif

FILE: src/i2a_pkg.sv
// types, constants and helpers of the integer to ascii formatter
`default_nettype none

package i2a_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned DEC_DIGITS = 10;
  localparam int unsigned HEX_DIGITS = 8;
  localparam int unsigned DIG_W      = 4 * DEC_DIGITS;
  localparam int unsigned NDIG_W     = 4;
  localparam int unsigned CONV_STEPS = VALUE_W;
  localparam int unsigned CNT_W      = $clog2(CONV_STEPS);

  localparam logic [1:0] FUNC_SDEC    = 2'd1;
  localparam int unsigned FUNC_HEX_BIT = 1;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CHAR_X     = 7'h78;

  typedef struct packed {
    logic [1:0]         func;
    logic [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic               hex;
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PFX,
    ST_CONV,
    ST_SKIP,
    ST_DIG
  } state_e;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    logic [CHAR_W-1:0] ext;
    ext = {3'b000, d};
    if (d < 4'd10) begin
      return CHAR_ZERO + ext;
    end else begin
      return CHAR_A + ext - 7'd10;
    end
  endfunction

endpackage

`default_nettype wire

FILE: src/integer_to_ascii_formatter.sv
// top level of the integer to ascii formatter
`default_nettype none

// Formats a 32-bit value as ASCII text, one character per output item, with last set on
// the final character: unsigned decimal, signed decimal ('-' then the magnitude) or hex
// ("0x" then uppercase digits), leading zeros suppressed. The front end classifies each
// input item and places it in a small queue (QUEUE_DEPTH entries), so new items are taken
// while the back end is busy, until the queue is full. The back end handles one item at a time:
// it takes the job, emits the prefix characters, then for decimal runs a bit-serial
// shift-and-add-3 conversion of 32 steps, then drops suppressed leading zeros (up to 9, up to 7
// for hex) one by one, and then emits the digits. Prefix and digit characters wait while the
// output is stalled. The output has a register stage and no reset-time pass.
module integer_to_ascii_formatter #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire i2a_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output i2a_pkg::out_item_t      out_item_o
);

  logic          q_full;
  logic          q_empty;
  logic          push;
  logic          pop;
  i2a_pkg::job_t push_job;
  i2a_pkg::job_t pop_job;

  i2a_front u_front (
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .job_o      (push_job)
  );

  i2a_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .full_o     (q_full),
    .empty_o    (q_empty),
    .pop_job_o  (pop_job)
  );

  i2a_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!q_empty),
    .job_i       (pop_job),
    .job_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

FILE: src/i2a_front.sv
// front end: accepts items and turns them into mode, sign and magnitude jobs
`default_nettype none

module i2a_front (
  input  wire logic              in_valid_i,
  input  wire i2a_pkg::in_item_t in_item_i,
  input  wire logic              q_full_i,
  output logic                   in_stall_o,
  output logic                   push_o,
  output i2a_pkg::job_t          job_o
);

  logic hex;
  logic neg;

  assign hex        = in_item_i.func[i2a_pkg::FUNC_HEX_BIT];
  assign neg        = !hex && (in_item_i.func == i2a_pkg::FUNC_SDEC) &&
                      in_item_i.value[i2a_pkg::VALUE_W-1];
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    job_o.hex = hex;
    job_o.neg = neg;
    job_o.mag = neg ? (~in_item_i.value + 32'd1) : in_item_i.value;
  end

endmodule

`default_nettype wire

FILE: src/i2a_queue.sv
// short job queue between front and back end
`default_nettype none

module i2a_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire i2a_pkg::job_t push_job_i,
  input  wire logic          pop_i,
  output logic               full_o,
  output logic               empty_o,
  output i2a_pkg::job_t      pop_job_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  i2a_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_push;
  logic do_pop;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_job_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/i2a_back.sv
// back end: bit-serial decimal conversion, zero suppression and character output
`default_nettype none

`include "integer_to_ascii_formatter_defines.svh"

module i2a_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          job_valid_i,
  input  wire i2a_pkg::job_t job_i,
  output logic               job_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output i2a_pkg::out_item_t out_item_o
);

  localparam int unsigned DigW = i2a_pkg::DIG_W;

  i2a_pkg::state_e state_q, state_d;
  logic [DigW-1:0]                 dig_q, dig_d;
  logic [i2a_pkg::VALUE_W-1:0]     bin_q, bin_d;
  logic [i2a_pkg::CNT_W-1:0]       cnt_q, cnt_d;
  logic [i2a_pkg::NDIG_W-1:0]      ndig_q, ndig_d;
  logic [1:0]                      pfx_q, pfx_d;
  logic                            hex_q, hex_d;
  logic                            out_valid_q, out_valid_d;
  i2a_pkg::out_item_t              out_q, out_d;
  logic                            emit;
  logic                            emit_ok;
  i2a_pkg::out_item_t              emit_item;
  logic [DigW-1:0]                 adj;
  logic [3:0]                      top;

  assign emit_ok = !out_valid_q || !out_stall_i;
  assign top     = dig_q[DigW-1 -: 4];

  // add-3 correction on every bcd digit
  always_comb begin
    for (int i = 0; i < i2a_pkg::DEC_DIGITS; i++) begin
      adj[4*i +: 4] = (dig_q[4*i +: 4] >= 4'd5) ? dig_q[4*i +: 4] + 4'd3 : dig_q[4*i +: 4];
    end
  end

  always_comb begin
    state_d   = state_q;
    dig_d     = dig_q;
    bin_d     = bin_q;
    cnt_d     = cnt_q;
    ndig_d    = ndig_q;
    pfx_d     = pfx_q;
    hex_d     = hex_q;
    job_pop_o = 1'b0;
    emit      = 1'b0;
    emit_item = '0;
    case (state_q)
      i2a_pkg::ST_IDLE: begin
        job_pop_o = job_valid_i;
        if (job_valid_i) begin
          hex_d  = job_i.hex;
          bin_d  = job_i.mag;
          cnt_d  = '0;
          dig_d  = job_i.hex ? {job_i.mag, 8'h00} : '0;
          ndig_d = job_i.hex ? i2a_pkg::NDIG_W'(i2a_pkg::HEX_DIGITS)
                             : i2a_pkg::NDIG_W'(i2a_pkg::DEC_DIGITS);
          pfx_d  = job_i.hex ? 2'd2 : (job_i.neg ? 2'd1 : 2'd0);
          if (job_i.hex || job_i.neg) begin
            state_d = i2a_pkg::ST_PFX;
          end else begin
            state_d = i2a_pkg::ST_CONV;
          end
        end
      end
      i2a_pkg::ST_PFX: begin
        emit = 1'b1;
        if (!hex_q) begin
          emit_item.char_code = i2a_pkg::CHAR_MINUS;
        end else if (pfx_q == 2'd2) begin
          emit_item.char_code = i2a_pkg::CHAR_ZERO;
        end else begin
          emit_item.char_code = i2a_pkg::CHAR_X;
        end
        if (emit_ok) begin
          pfx_d = pfx_q - 2'd1;
          if (pfx_q == 2'd1) begin
            state_d = hex_q ? i2a_pkg::ST_SKIP : i2a_pkg::ST_CONV;
          end
        end
      end
      i2a_pkg::ST_CONV: begin
        dig_d = {adj[DigW-2:0], bin_q[i2a_pkg::VALUE_W-1]};
        bin_d = {bin_q[i2a_pkg::VALUE_W-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == i2a_pkg::CNT_W'(i2a_pkg::CONV_STEPS - 1)) begin
          state_d = i2a_pkg::ST_SKIP;
        end
      end
      i2a_pkg::ST_SKIP: begin
        if (ndig_q > 4'd1 && top == 4'd0) begin
          dig_d  = {dig_q[DigW-5:0], 4'h0};
          ndig_d = ndig_q - 1'b1;
        end else begin
          state_d = i2a_pkg::ST_DIG;
        end
      end
      i2a_pkg::ST_DIG: begin
        emit                = 1'b1;
        emit_item.char_code = i2a_pkg::digit_char(top);
        emit_item.last      = (ndig_q == 4'd1);
        if (emit_ok) begin
          dig_d  = {dig_q[DigW-5:0], 4'h0};
          ndig_d = ndig_q - 1'b1;
          if (ndig_q == 4'd1) begin
            state_d = i2a_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = i2a_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit && emit_ok) begin
      out_valid_d = 1'b1;
      out_d       = emit_item;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= i2a_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q  <= dig_d;
    bin_q  <= bin_d;
    cnt_q  <= cnt_d;
    ndig_q <= ndig_d;
    pfx_q  <= pfx_d;
    hex_q  <= hex_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `I2A_ASSERT_IMPL(a_dig_count, state_q == i2a_pkg::ST_DIG, (ndig_q != 4'd0) && (ndig_q <= 4'd10))
  `I2A_ASSERT_IMPL(a_pfx_left, state_q == i2a_pkg::ST_PFX, pfx_q != 2'd0)
  `I2A_ASSERT_IMPL(a_bcd_top, state_q == i2a_pkg::ST_CONV, top <= 4'd9)
  `I2A_ASSERT_NEXT(a_last_idle, emit && emit_ok && emit_item.last, state_q == i2a_pkg::ST_IDLE)

endmodule

`default_nettype wire
